// File: hw/rtl/cle_pkg.sv
package cle_pkg;

    localparam int BUFFER_DEPTH = 128;
    localparam int PTR_SPAN     = 2 * BUFFER_DEPTH;
    localparam int PTR_W        = $clog2(PTR_SPAN);
    localparam int SLOT_W       = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

    localparam logic [7:0] KEY_DEL    = 8'h7F;
    localparam logic [7:0] KEY_CTRL_U = 8'h15;
    localparam logic [7:0] KEY_CTRL_H = 8'h08;
    localparam logic [7:0] KEY_CTRL_D = 8'h04;
    localparam logic [7:0] KEY_CTRL_P = 8'h10;
    localparam logic [7:0] KEY_CR     = 8'h0D;
    localparam logic [7:0] KEY_LF     = 8'h0A;
    localparam logic [7:0] KEY_NUL    = 8'h00;

    localparam logic [0:0] CMD_KEY  = 1'b0;
    localparam logic [0:0] CMD_READ = 1'b1;

    localparam logic [1:0] KIND_ECHO       = 2'd0;
    localparam logic [1:0] KIND_ERASE      = 2'd1;
    localparam logic [1:0] KIND_READ_DATA  = 2'd2;
    localparam logic [1:0] KIND_READ_EMPTY = 2'd3;

    typedef logic [PTR_W-1:0]  cle_ptr_t;
    typedef logic [SLOT_W-1:0] cle_slot_t;
    typedef logic [CNT_W-1:0]  cle_cnt_t;

    typedef struct packed {
        logic [0:0] command;
        logic [7:0] key_char;
    } cle_req_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] erase_count;
        logic [0:0] line_ready;
    } cle_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_KILL
    } cle_state_t;

    function automatic cle_ptr_t ptr_inc(input cle_ptr_t p);
        return (p == PTR_W'(PTR_SPAN - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic cle_ptr_t ptr_dec(input cle_ptr_t p);
        return (p == '0) ? PTR_W'(PTR_SPAN - 1) : p - PTR_W'(1);
    endfunction

    // distance from b forward to a, modulo the pointer span
    function automatic cle_ptr_t ptr_dist(input cle_ptr_t a, input cle_ptr_t b);
        logic [PTR_W:0] sum;
        sum = {1'b0, a} + (PTR_W + 1)'(PTR_SPAN) - {1'b0, b};
        if (a >= b)
            return a - b;
        return sum[PTR_W-1:0];
    endfunction

    function automatic cle_slot_t ptr_slot(input cle_ptr_t p);
        cle_ptr_t s;
        s = (p >= PTR_W'(BUFFER_DEPTH)) ? p - PTR_W'(BUFFER_DEPTH) : p;
        return s[SLOT_W-1:0];
    endfunction

    function automatic logic [7:0] sat_count(input cle_cnt_t c);
        return (32'(c) > 32'd255) ? 8'hFF : 8'(c);
    endfunction

endpackage

// File: hw/rtl/console_line_editor_core.sv
// Channel   Ports                          Handshake
// -------   -----------------------------  ------------------------------------
// request   start, busy, request           taken when start is high, busy low
// result    result_valid, result           shown one cycle, taken at its end
//
// A typed key, an erase of one character or an empty read gives its result
// in the cycle after the request. A read with data passes through the
// registered read port of the line store and then the output register. Ctrl-U
// erases n characters (up to BUFFER_DEPTH - 1), walking back one entry a cycle.
// Reset clears the three pointers and the sequencer; the store is not
// cleared. The receiver cannot stall: each result is shown for one cycle.
module console_line_editor_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cle_pkg::cle_req_t request,
    output logic              result_valid,
    output cle_pkg::cle_rsp_t result
);
    import cle_pkg::*;

    logic       rsp_fire;
    cle_rsp_t   rsp;
    logic       ram_we;
    logic       ram_re;
    cle_slot_t  ram_addr;
    logic [7:0] ram_wdata;
    logic [7:0] ram_rdata;

    logic       result_valid_reg;
    cle_rsp_t   result_reg;

    // Sequencer: pointers, key decoding and the kill-line walk.
    cle_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .busy      (busy),
        .rsp_fire  (rsp_fire),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_re    (ram_re),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

    // Circular line store, one access a cycle.
    cle_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Register each result; result_valid is high for exactly one cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= rsp_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_fire)
        begin
            result_reg <= rsp;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: hw/rtl/cle_ram.sv
module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/cle_seq.sv
module cle_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  cle_pkg::cle_req_t request,
    output logic              busy,
    output logic              rsp_fire,
    output cle_pkg::cle_rsp_t rsp,
    output logic              ram_we,
    output logic              ram_re,
    output cle_pkg::cle_slot_t ram_addr,
    output logic [7:0]        ram_wdata,
    input  logic [7:0]        ram_rdata
);
    import cle_pkg::*;

    cle_state_t state_reg, state_next;
    cle_ptr_t   rd_ptr_reg, rd_ptr_next;
    cle_ptr_t   cm_ptr_reg, cm_ptr_next;
    cle_ptr_t   ed_ptr_reg, ed_ptr_next;
    cle_cnt_t   cnt_reg, cnt_next;

    cle_ptr_t   ed_dec1;
    cle_ptr_t   ed_dec2;
    cle_ptr_t   ed_inc;
    logic [7:0] key_mapped;
    logic       accept;

    assign ed_dec1    = ptr_dec(ed_ptr_reg);
    assign ed_dec2    = ptr_dec(ed_dec1);
    assign ed_inc     = ptr_inc(ed_ptr_reg);
    assign key_mapped = (request.key_char == KEY_CR) ? KEY_LF : request.key_char;
    assign accept     = start && (state_reg == ST_IDLE);
    assign busy       = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rd_ptr_reg <= '0;
            cm_ptr_reg <= '0;
            ed_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_ptr_reg <= rd_ptr_next;
            cm_ptr_reg <= cm_ptr_next;
            ed_ptr_reg <= ed_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        rd_ptr_next = rd_ptr_reg;
        cm_ptr_next = cm_ptr_reg;
        ed_ptr_next = ed_ptr_reg;
        cnt_next    = cnt_reg;
        rsp_fire    = 1'b0;
        rsp         = '0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_addr    = ptr_slot(ed_ptr_reg);
        ram_wdata   = key_mapped;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (request.command == CMD_READ)
                    begin
                        if (rd_ptr_reg != cm_ptr_reg)
                        begin
                            ram_re      = 1'b1;
                            ram_addr    = ptr_slot(rd_ptr_reg);
                            rd_ptr_next = ptr_inc(rd_ptr_reg);
                            state_next  = ST_READ;
                        end
                        else
                        begin
                            rsp_fire = 1'b1;
                            rsp.kind = KIND_READ_EMPTY;
                        end
                    end
                    else if (request.key_char == KEY_CTRL_P)
                    begin
                        // ignored key
                    end
                    else if (request.key_char == KEY_CTRL_U)
                    begin
                        if (ed_ptr_reg != cm_ptr_reg)
                        begin
                            ram_re     = 1'b1;
                            ram_addr   = ptr_slot(ed_dec1);
                            cnt_next   = '0;
                            state_next = ST_KILL;
                        end
                    end
                    else if (request.key_char == KEY_CTRL_H || request.key_char == KEY_DEL)
                    begin
                        if (ed_ptr_reg != cm_ptr_reg)
                        begin
                            ed_ptr_next     = ed_dec1;
                            rsp_fire        = 1'b1;
                            rsp.kind        = KIND_ERASE;
                            rsp.erase_count = 8'd1;
                        end
                    end
                    else if (request.key_char != KEY_NUL &&
                             ptr_dist(ed_ptr_reg, rd_ptr_reg) < PTR_W'(BUFFER_DEPTH))
                    begin
                        ram_we      = 1'b1;
                        ed_ptr_next = ed_inc;
                        rsp_fire    = 1'b1;
                        rsp.kind    = KIND_ECHO;
                        rsp.data    = key_mapped;
                        if (key_mapped == KEY_LF || key_mapped == KEY_CTRL_D ||
                            ptr_dist(ed_inc, rd_ptr_reg) == PTR_W'(BUFFER_DEPTH))
                        begin
                            cm_ptr_next    = ed_inc;
                            rsp.line_ready = 1'b1;
                        end
                    end
                end
            end

            ST_READ:
            begin
                rsp_fire   = 1'b1;
                rsp.kind   = KIND_READ_DATA;
                rsp.data   = ram_rdata;
                state_next = ST_IDLE;
            end

            ST_KILL:
            begin
                // read data holds the entry just before the edit point
                if (ram_rdata != KEY_LF)
                begin
                    ed_ptr_next = ed_dec1;
                    cnt_next    = cnt_reg + CNT_W'(1);
                    if (ed_dec1 != cm_ptr_reg)
                    begin
                        ram_re   = 1'b1;
                        ram_addr = ptr_slot(ed_dec2);
                    end
                    else
                    begin
                        rsp_fire        = 1'b1;
                        rsp.kind        = KIND_ERASE;
                        rsp.erase_count = sat_count(cnt_reg + CNT_W'(1));
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    rsp_fire        = (cnt_reg != '0);
                    rsp.kind        = KIND_ERASE;
                    rsp.erase_count = sat_count(cnt_reg);
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
